/* rtl/pkthdr_pkg.sv */
`default_nettype none

package pkthdr_pkg;

   localparam int MaxBytes = 6;
   localparam int CountWidth = $clog2(MaxBytes + 1);

   localparam logic [1:0] MODE_FIXED   = 2'd0;
   localparam logic [1:0] MODE_BLOCK   = 2'd1;
   localparam logic [1:0] MODE_PARTIAL = 2'd2;

   typedef logic [MaxBytes-1:0][7:0] bytes_type;

   typedef struct packed {
      bytes_type               bytes;
      logic [CountWidth-1:0]   count;
      logic [1:0]              mode;
      logic                    status;
   } header_type;

endpackage

`default_nettype wire

/* rtl/packet_header_encoder_top.sv */
`default_nettype none

// Packet header encoder. Each item accepted on start (while busy is low) is a
// packet description, and its header leaves as one to six bytes, one byte per
// clock cycle on consecutive cycles, each marked by rsp_valid for exactly one
// cycle, with rsp_last_byte and rsp_stream_mode on the final byte. The receiver
// cannot stall, so every byte must be taken in the cycle it is shown. An item
// occupies the byte shift register until its bytes are out; busy drops during
// the cycle that moves the last byte out, so the next item is accepted then
// and its first byte follows directly. The first byte passes through the shift
// register and then the output register before it reaches the result ports.

module packet_header_encoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [5:0]  req_packet_tag,
   input  wire logic        req_new_format,
   input  wire logic [31:0] req_body_length,
   input  wire logic [2:0]  req_length_hint,
   input  wire logic        req_block_enable,
   input  wire logic        req_legacy_sig_form,
   output logic             rsp_valid,
   output logic [7:0]       rsp_header_byte,
   output logic             rsp_last_byte,
   output logic [1:0]       rsp_stream_mode,
   output logic             rsp_status
);

   pkthdr_pkg::header_type header;
   logic                   load;

   assign load = start && !busy;

   pkthdr_encode u_encode (
      .req_packet_tag      (req_packet_tag),
      .req_new_format      (req_new_format),
      .req_body_length     (req_body_length),
      .req_length_hint     (req_length_hint),
      .req_block_enable    (req_block_enable),
      .req_legacy_sig_form (req_legacy_sig_form),
      .header              (header)
   );

   pkthdr_serializer u_serializer (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .header          (header),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_header_byte (rsp_header_byte),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_stream_mode (rsp_stream_mode),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire

/* rtl/pkthdr_encode.sv */
`default_nettype none

module pkthdr_encode (
   input  wire logic [5:0]         req_packet_tag,
   input  wire logic               req_new_format,
   input  wire logic [31:0]        req_body_length,
   input  wire logic [2:0]         req_length_hint,
   input  wire logic               req_block_enable,
   input  wire logic               req_legacy_sig_form,
   output pkthdr_pkg::header_type  header
);

   localparam logic [1:0] LTYPE_ONE   = 2'd0;
   localparam logic [1:0] LTYPE_TWO   = 2'd1;
   localparam logic [1:0] LTYPE_FOUR  = 2'd2;
   localparam logic [1:0] LTYPE_INDET = 2'd3;

   localparam logic [7:0] TAG_LEGACY = 8'h89;
   localparam logic [7:0] TAG_NEW    = 8'hc0;
   localparam logic [7:0] TAG_OLD    = 8'h80;

   logic        len_zero;
   logic        len_lt_192;
   logic        len_lt_8384;
   logic        len_lt_256;
   logic        len_lt_65536;
   logic [12:0] two_rem;
   logic [1:0]  ltype;

   assign len_zero     = (req_body_length == 32'd0);
   assign len_lt_192   = (req_body_length < 32'd192);
   assign len_lt_8384  = (req_body_length < 32'd8384);
   assign len_lt_256   = (req_body_length < 32'd256);
   assign len_lt_65536 = (req_body_length < 32'd65536);
   assign two_rem      = req_body_length[12:0] - 13'd192;

   always_comb begin
      priority if (len_zero) begin
         ltype = LTYPE_INDET;
      end else if (req_length_hint != 3'd0) begin
         priority if (req_length_hint == 3'd2 && len_lt_256) begin
            ltype = LTYPE_ONE;
         end else if (req_length_hint == 3'd3 && len_lt_65536) begin
            ltype = LTYPE_TWO;
         end else begin
            ltype = LTYPE_FOUR;
         end
      end else if (len_lt_256) begin
         ltype = LTYPE_ONE;
      end else if (len_lt_65536) begin
         ltype = LTYPE_TWO;
      end else begin
         ltype = LTYPE_FOUR;
      end
   end

   always_comb begin
      header.bytes  = '0;
      header.count  = pkthdr_pkg::CountWidth'(1);
      header.mode   = pkthdr_pkg::MODE_FIXED;
      header.status = 1'b0;
      priority if (req_legacy_sig_form) begin
         header.bytes[0] = TAG_LEGACY;
         header.bytes[1] = req_body_length[15:8];
         header.bytes[2] = req_body_length[7:0];
         header.count    = pkthdr_pkg::CountWidth'(3);
      end else if (req_new_format || req_packet_tag[5:4] != 2'b00) begin
         header.status   = (req_length_hint != 3'd0);
         header.bytes[0] = TAG_NEW | {2'b00, req_packet_tag};
         priority if (len_zero) begin
            header.mode = pkthdr_pkg::MODE_PARTIAL;
         end else if (len_lt_192) begin
            header.bytes[1] = req_body_length[7:0];
            header.count    = pkthdr_pkg::CountWidth'(2);
         end else if (len_lt_8384) begin
            header.bytes[1] = {3'b110, two_rem[12:8]};
            header.bytes[2] = two_rem[7:0];
            header.count    = pkthdr_pkg::CountWidth'(3);
         end else begin
            header.bytes[1] = 8'hff;
            header.bytes[2] = req_body_length[31:24];
            header.bytes[3] = req_body_length[23:16];
            header.bytes[4] = req_body_length[15:8];
            header.bytes[5] = req_body_length[7:0];
            header.count    = pkthdr_pkg::CountWidth'(6);
         end
      end else begin
         header.bytes[0] = TAG_OLD | {2'b00, req_packet_tag[3:0], ltype};
         unique case (ltype)
            LTYPE_INDET: begin
               if (req_block_enable) begin
                  header.mode = pkthdr_pkg::MODE_BLOCK;
               end
            end
            LTYPE_ONE: begin
               header.bytes[1] = req_body_length[7:0];
               header.count    = pkthdr_pkg::CountWidth'(2);
            end
            LTYPE_TWO: begin
               header.bytes[1] = req_body_length[15:8];
               header.bytes[2] = req_body_length[7:0];
               header.count    = pkthdr_pkg::CountWidth'(3);
            end
            default: begin
               header.bytes[1] = req_body_length[31:24];
               header.bytes[2] = req_body_length[23:16];
               header.bytes[3] = req_body_length[15:8];
               header.bytes[4] = req_body_length[7:0];
               header.count    = pkthdr_pkg::CountWidth'(5);
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* rtl/pkthdr_serializer.sv */
`default_nettype none

module pkthdr_serializer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire pkthdr_pkg::header_type  header,
   output logic                         busy,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_header_byte,
   output logic                         rsp_last_byte,
   output logic [1:0]                   rsp_stream_mode,
   output logic                         rsp_status
);

   localparam int CW = pkthdr_pkg::CountWidth;

   pkthdr_pkg::bytes_type shift_ff, shift_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [1:0]            mode_ff, mode_in;
   logic                  status_ff, status_in;
   logic                  valid_ff;
   logic [7:0]            byte_ff;
   logic                  last_ff;
   logic [1:0]            omode_ff;
   logic                  ostatus_ff;
   logic                  emitting;

   assign emitting = (cnt_ff != '0);
   assign busy     = (cnt_ff > CW'(1));

   always_comb begin
      shift_in  = shift_ff;
      cnt_in    = cnt_ff;
      mode_in   = mode_ff;
      status_in = status_ff;
      if (load) begin
         shift_in  = header.bytes;
         cnt_in    = header.count;
         mode_in   = header.mode;
         status_in = header.status;
      end else if (emitting) begin
         for (int i = 0; i < pkthdr_pkg::MaxBytes - 1; i++) begin
            shift_in[i] = shift_ff[i + 1];
         end
         shift_in[pkthdr_pkg::MaxBytes - 1] = 8'h00;
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      mode_ff    <= mode_in;
      status_ff  <= status_in;
      byte_ff    <= shift_ff[0];
      last_ff    <= (cnt_ff == CW'(1));
      omode_ff   <= (cnt_ff == CW'(1)) ? mode_ff : pkthdr_pkg::MODE_FIXED;
      ostatus_ff <= status_ff;
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= emitting;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_header_byte = byte_ff;
   assign rsp_last_byte   = last_ff;
   assign rsp_stream_mode = omode_ff;
   assign rsp_status      = ostatus_ff;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top;

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned DrainCycles = 16;
   localparam int unsigned MaxReports = 10;

   localparam logic [1:0] LEN_ONE   = 2'd0;
   localparam logic [1:0] LEN_TWO   = 2'd1;
   localparam logic [1:0] LEN_FOUR  = 2'd2;
   localparam logic [1:0] LEN_INDET = 2'd3;

   localparam logic [7:0] LEGACY_TAG_BYTE = 8'h89;
   localparam logic [7:0] NEW_TAG_BASE    = 8'hc0;
   localparam logic [7:0] FIVE_BYTE_MARK  = 8'hff;

   typedef struct {
      logic [5:0]  tag;
      logic        new_fmt;
      logic [31:0] length;
      logic [2:0]  hint;
      logic        blk;
      logic        legacy;
      int unsigned gap;
      bit          drain;
   } pkt_item_type;

   typedef struct {
      logic [7:0]  value;
      logic        last;
      logic [1:0]  mode;
      logic        status;
      int unsigned accepted_at;
   } hdr_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [5:0]  req_packet_tag = '0;
   logic        req_new_format = 1'b0;
   logic [31:0] req_body_length = '0;
   logic [2:0]  req_length_hint = '0;
   logic        req_block_enable = 1'b0;
   logic        req_legacy_sig_form = 1'b0;
   logic        rsp_valid;
   logic [7:0]  rsp_header_byte;
   logic        rsp_last_byte;
   logic [1:0]  rsp_stream_mode;
   logic        rsp_status;

   pkt_item_type pending_items[$];
   hdr_byte_type expected_bytes[$];
   pkt_item_type driving;
   int unsigned  gap_left = 0;
   int unsigned  cycle_count = 0;
   int unsigned  mismatches = 0;

   packet_header_encoder_top u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_packet_tag(req_packet_tag),
      .req_new_format(req_new_format),
      .req_body_length(req_body_length),
      .req_length_hint(req_length_hint),
      .req_block_enable(req_block_enable),
      .req_legacy_sig_form(req_legacy_sig_form),
      .rsp_valid(rsp_valid),
      .rsp_header_byte(rsp_header_byte),
      .rsp_last_byte(rsp_last_byte),
      .rsp_stream_mode(rsp_stream_mode),
      .rsp_status(rsp_status)
   );

   always #10 clock = ~clock;

   task automatic encode_header(input pkt_item_type p, input int unsigned at);
      logic [7:0]   seq[pkthdr_pkg::MaxBytes];
      int           n;
      logic [1:0]   mode;
      logic         st;
      logic [1:0]   ltype;
      logic [31:0]  rem;
      hdr_byte_type b;
      n = 0;
      mode = pkthdr_pkg::MODE_FIXED;
      st = 1'b0;
      if (p.legacy) begin
         seq[0] = LEGACY_TAG_BYTE;
         seq[1] = p.length[15:8];
         seq[2] = p.length[7:0];
         n = 3;
      end else if (p.new_fmt || p.tag > 6'd15) begin
         st = (p.hint != 3'd0);
         seq[0] = NEW_TAG_BASE | {2'b00, p.tag};
         n = 1;
         if (p.length == 32'd0) begin
            mode = pkthdr_pkg::MODE_PARTIAL;
         end else if (p.length < 32'd192) begin
            seq[1] = p.length[7:0];
            n = 2;
         end else if (p.length < 32'd8384) begin
            rem = p.length - 32'd192;
            seq[1] = 8'(rem / 256 + 192);
            seq[2] = rem[7:0];
            n = 3;
         end else begin
            seq[1] = FIVE_BYTE_MARK;
            seq[2] = p.length[31:24];
            seq[3] = p.length[23:16];
            seq[4] = p.length[15:8];
            seq[5] = p.length[7:0];
            n = 6;
         end
      end else begin
         if (p.length == 32'd0) begin
            ltype = LEN_INDET;
         end else if (p.hint != 3'd0) begin
            if (p.hint == 3'd2 && p.length < 32'd256) begin
               ltype = LEN_ONE;
            end else if (p.hint == 3'd3 && p.length < 32'd65536) begin
               ltype = LEN_TWO;
            end else begin
               ltype = LEN_FOUR;
            end
         end else if (p.length < 32'd256) begin
            ltype = LEN_ONE;
         end else if (p.length < 32'd65536) begin
            ltype = LEN_TWO;
         end else begin
            ltype = LEN_FOUR;
         end
         seq[0] = {2'b10, p.tag[3:0], ltype};
         n = 1;
         if (p.length == 32'd0) begin
            if (p.blk) begin
               mode = pkthdr_pkg::MODE_BLOCK;
            end
         end else begin
            if (ltype == LEN_FOUR) begin
               seq[n] = p.length[31:24];
               seq[n + 1] = p.length[23:16];
               n = n + 2;
            end
            if (ltype != LEN_ONE) begin
               seq[n] = p.length[15:8];
               n = n + 1;
            end
            seq[n] = p.length[7:0];
            n = n + 1;
         end
      end
      for (int i = 0; i < n; i++) begin
         b.value = seq[i];
         b.last = (i == n - 1);
         b.mode = (i == n - 1) ? mode : pkthdr_pkg::MODE_FIXED;
         b.status = st;
         b.accepted_at = at;
         expected_bytes.push_back(b);
      end
   endtask

   task automatic add_item(input logic [5:0] tag, input logic new_fmt,
                           input logic [31:0] length, input logic [2:0] hint,
                           input logic blk, input logic legacy,
                           input int unsigned gap);
      pkt_item_type p;
      p.tag = tag;
      p.new_fmt = new_fmt;
      p.length = length;
      p.hint = hint;
      p.blk = blk;
      p.legacy = legacy;
      p.gap = gap;
      p.drain = 1'b0;
      pending_items.push_back(p);
   endtask

   always @(posedge clock) begin : driver
      logic ready;
      if (reset) begin
         start <= 1'b0;
      end else begin
         ready = !start;
         if (start && !busy) begin
            encode_header(driving, cycle_count);
            ready = 1'b1;
         end
         if (ready) begin
            if (gap_left != 0) begin
               gap_left = gap_left - 1;
               start <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         (!pending_items[0].drain || expected_bytes.size() == 0)) begin
               driving = pending_items.pop_front();
               gap_left = driving.gap;
               req_packet_tag <= driving.tag;
               req_new_format <= driving.new_fmt;
               req_body_length <= driving.length;
               req_length_hint <= driving.hint;
               req_block_enable <= driving.blk;
               req_legacy_sig_form <= driving.legacy;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      hdr_byte_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (expected_bytes.size() == 0 || expected_bytes[0].accepted_at == cycle_count) begin
            mismatches = mismatches + 1;
            if (mismatches <= MaxReports) begin
               $display("unexpected byte=%h last=%b mode=%0d status=%b", rsp_header_byte,
                        rsp_last_byte, rsp_stream_mode, rsp_status);
            end
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_header_byte !== want.value || rsp_last_byte !== want.last ||
                rsp_stream_mode !== want.mode || rsp_status !== want.status) begin
               mismatches = mismatches + 1;
               if (mismatches <= MaxReports) begin
                  $display("expected byte=%h last=%b mode=%0d status=%b,",
                           want.value, want.last, want.mode, want.status,
                           " got byte=%h last=%b mode=%0d status=%b",
                           rsp_header_byte, rsp_last_byte, rsp_stream_mode, rsp_status);
               end
            end
         end
      end
      if (cycle_count >= CycleLimit) begin
         $display("packet_header_encoder_top: mismatch");
         $finish;
      end
   end

   initial begin
      logic [31:0] length;
      logic [2:0]  hint;
      int unsigned gap;

      // Legacy signature form.
      add_item(6'd2, 1'b0, 32'd0, 3'd0, 1'b0, 1'b1, $urandom_range(0, 16));
      add_item(6'd63, 1'b1, 32'hffffffff, 3'd7, 1'b1, 1'b1, $urandom_range(0, 16));
      add_item(6'd5, 1'b0, 32'h00012345, 3'd2, 1'b0, 1'b1, 0);
      // New format, including forced by tag and with an ignored hint.
      add_item(6'd0, 1'b1, 32'd0, 3'd0, 1'b0, 1'b0, 0);
      add_item(6'd1, 1'b1, 32'd1, 3'd0, 1'b0, 1'b0, $urandom_range(0, 16));
      add_item(6'd11, 1'b1, 32'd191, 3'd0, 1'b0, 1'b0, 0);
      add_item(6'd16, 1'b0, 32'd192, 3'd0, 1'b0, 1'b0, 0);
      add_item(6'd63, 1'b0, 32'd8383, 3'd0, 1'b0, 1'b0, $urandom_range(0, 16));
      add_item(6'd20, 1'b1, 32'd8384, 3'd5, 1'b0, 1'b0, 0);
      add_item(6'd40, 1'b1, 32'hffffffff, 3'd0, 1'b0, 1'b0, 0);
      add_item(6'd7, 1'b1, 32'd0, 3'd3, 1'b1, 1'b0, $urandom_range(0, 16));
      // Old format.
      add_item(6'd15, 1'b0, 32'd0, 3'd0, 1'b0, 1'b0, 0);
      add_item(6'd14, 1'b0, 32'd0, 3'd0, 1'b1, 1'b0, 0);
      add_item(6'd3, 1'b0, 32'd0, 3'd3, 1'b0, 1'b0, $urandom_range(0, 16));
      add_item(6'd0, 1'b0, 32'd255, 3'd0, 1'b0, 1'b0, 0);
      add_item(6'd9, 1'b0, 32'd256, 3'd0, 1'b0, 1'b0, 0);
      add_item(6'd10, 1'b0, 32'd65535, 3'd0, 1'b0, 1'b0, 0);
      add_item(6'd12, 1'b0, 32'd65536, 3'd0, 1'b0, 1'b0, $urandom_range(0, 16));
      add_item(6'd4, 1'b0, 32'd255, 3'd2, 1'b0, 1'b0, 0);
      add_item(6'd6, 1'b0, 32'd256, 3'd2, 1'b0, 1'b0, 0);
      add_item(6'd8, 1'b0, 32'd65535, 3'd3, 1'b0, 1'b0, 0);
      add_item(6'd13, 1'b0, 32'd65536, 3'd3, 1'b0, 1'b0, $urandom_range(0, 16));
      add_item(6'd1, 1'b0, 32'd1, 3'd7, 1'b0, 1'b0, 0);
      add_item(6'd2, 1'b0, 32'd1, 3'd1, 1'b0, 1'b0, 0);
      add_item(6'd15, 1'b0, 32'hffffffff, 3'd4, 1'b1, 1'b0, 0);

      for (int i = 0; i < 185; i++) begin
         case ($urandom_range(0, 7))
            0: length = 32'd0;
            1: length = $urandom_range(1, 191);
            2: length = $urandom_range(192, 8383);
            3: length = $urandom_range(8384, 65535);
            4: length = $urandom_range(250, 262);
            5: length = $urandom_range(65530, 65542);
            default: length = $urandom;
         endcase
         hint = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(0, 7));
         gap = ((i / 15) % 3 == 1) ? 0 : $urandom_range(0, 16);
         add_item(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), length, hint,
                  1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0), gap);
         if (i == 0 || $urandom_range(0, 39) == 0) begin
            pending_items[$].drain = 1'b1;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || start || expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("packet_header_encoder_top: match");
      end else begin
         $display("packet_header_encoder_top: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
rtl/pkthdr_pkg.sv
rtl/pkthdr_encode.sv
rtl/pkthdr_serializer.sv
rtl/packet_header_encoder_top.sv
tb/sv/tb_top.sv
